// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CBMT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cbmt assertion failed");

// Condition that must never hold outside reset.
`define CBMT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("cbmt forbidden condition");

`endif

// ===== rtl/core/cbmt_pkg.sv =====
`timescale 1ns / 1ps
package cbmt_pkg;

   localparam int NUM_COUNTERS = 256;
   localparam int COUNT_WIDTH  = 16;
   localparam int NUM_BUCKETS  = NUM_COUNTERS + 1;
   localparam int CIDX_W       = 8;
   localparam int BIDX_W       = $clog2(NUM_BUCKETS);
   localparam int SIZE_W       = $clog2(NUM_COUNTERS + 1);

   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_INC  = 2'd0,
      CMD_DEC  = 2'd1,
      CMD_CLR  = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [COUNT_WIDTH-1:0] val;
      logic [SIZE_W-1:0]             size;
      logic [BIDX_W-1:0]             prev;
      logic [BIDX_W-1:0]             next;
   } bkt_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BOC,
      ST_BRD,
      ST_WALK,
      ST_WCHK,
      ST_INS,
      ST_INSQ,
      ST_INSP,
      ST_TRD,
      ST_TWR,
      ST_BCHK,
      ST_RLP,
      ST_RLPW,
      ST_RLN,
      ST_RLNW,
      ST_BOCW,
      ST_HRD,
      ST_HCAP
   } state_type;

endpackage

// ===== rtl/core/cbmt_chan_if.sv =====
`timescale 1ns / 1ps
interface cbmt_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  command;
   logic [cbmt_pkg::CIDX_W-1:0] counter_index;

   modport source (output valid, command, counter_index, input ready);
   modport sink   (input valid, command, counter_index, output ready);
endinterface

interface cbmt_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [cbmt_pkg::COUNT_WIDTH-1:0] counter_value;
   logic signed [cbmt_pkg::COUNT_WIDTH-1:0] max_value;
   logic [cbmt_pkg::SIZE_W-1:0]             num_at_max;

   modport source (output valid, counter_value, max_value, num_at_max, input ready);
   modport sink   (input valid, counter_value, max_value, num_at_max, output ready);
endinterface

// ===== rtl/core/counter_bank_with_max_tracking.sv =====
`timescale 1ns / 1ps
// A read, a saturated command or a no-op clear looks up the counter's bucket and then reads the maximum
// bucket into the result register; a move also walks the sorted bucket list and re-links the buckets first.
// Throughput: one item at a time; the next item is accepted the cycle after the result is
// loaded. The result register frees the input side.
// Reset (synchronous, active high): all counters zero, one bucket; no memory sweep.
`include "assert_macros.svh"
module counter_bank_with_max_tracking (
   input  logic        clock,
   input  logic        reset,
   cbmt_req_if.sink    req_ch,
   cbmt_rsp_if.source  rsp_ch
);
   localparam int BW = $bits(cbmt_pkg::bkt_type);
   localparam cbmt_pkg::bkt_type BKT_INIT = '{
      val: '0, size: cbmt_pkg::SIZE_W'(cbmt_pkg::NUM_COUNTERS), prev: '0, next: '0};

   cbmt_pkg::state_type state_ff, state_in;

   logic [cbmt_pkg::CIDX_W-1:0] idx_ff, idx_in;
   cbmt_pkg::cmd_type           cmd_ff, cmd_in;
   logic [cbmt_pkg::BIDX_W-1:0] b_ff, b_in, p_ff, p_in, q_ff, q_in, t_ff, t_in;
   cbmt_pkg::bkt_type           pw_ff, pw_in, qw_ff, qw_in;
   logic signed [cbmt_pkg::COUNT_WIDTH-1:0] v_ff, v_in, cv_ff, cv_in;
   logic                        up_ff, up_in;
   logic [cbmt_pkg::BIDX_W-1:0] lowest_ff, lowest_in, highest_ff, highest_in;
   logic [cbmt_pkg::BIDX_W-1:0] stk_cnt_ff, stk_cnt_in, fresh_ff, fresh_in;
   logic [cbmt_pkg::NUM_COUNTERS-1:0] boc_vld_ff, boc_vld_in;
   logic                        b0_vld_ff, b0_vld_in;
   logic [cbmt_pkg::BIDX_W-1:0] bk_raddr_q_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [cbmt_pkg::COUNT_WIDTH-1:0] rsp_cv_ff, rsp_cv_in, rsp_max_ff, rsp_max_in;
   logic [cbmt_pkg::SIZE_W-1:0] rsp_num_ff, rsp_num_in;

   // memory ports
   logic                        boc_we;
   logic [cbmt_pkg::CIDX_W-1:0] boc_waddr, boc_raddr;
   logic [cbmt_pkg::BIDX_W-1:0] boc_wdata, boc_rdata;
   logic                        bk_we;
   logic [cbmt_pkg::BIDX_W-1:0] bk_waddr, bk_raddr;
   cbmt_pkg::bkt_type           bk_wdata, bk_rdata, bk_rd;
   logic                        stk_we;
   logic [cbmt_pkg::BIDX_W-1:0] stk_rdata;

   logic req_acc, rsp_load, moving, walk_eq, walk_end, walk_more, ins_edge;
   logic signed [cbmt_pkg::COUNT_WIDTH-1:0] new_val;
   logic [cbmt_pkg::BIDX_W-1:0] take_idx;

   cbmt_ram #(.WIDTH(cbmt_pkg::BIDX_W), .DEPTH(cbmt_pkg::NUM_COUNTERS)) u_boc_ram (
      .clock(clock), .we(boc_we), .waddr(boc_waddr), .wdata(boc_wdata),
      .raddr(boc_raddr), .rdata(boc_rdata));

   cbmt_ram #(.WIDTH(BW), .DEPTH(cbmt_pkg::NUM_BUCKETS)) u_bkt_ram (
      .clock(clock), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
      .raddr(bk_raddr), .rdata(bk_rdata));

   // free bucket stack; top entry is always being read
   cbmt_ram #(.WIDTH(cbmt_pkg::BIDX_W), .DEPTH(cbmt_pkg::NUM_BUCKETS)) u_stk_ram (
      .clock(clock), .we(stk_we), .waddr(stk_cnt_ff), .wdata(b_ff),
      .raddr(stk_cnt_ff - 1'b1), .rdata(stk_rdata));

   // bucket zero reads as the reset bucket until first written
   assign bk_rd = (!b0_vld_ff && bk_raddr_q_ff == '0) ? BKT_INIT : bk_rdata;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == cbmt_pkg::ST_HCAP) && (!rsp_valid_ff || rsp_ch.ready);
   assign walk_eq  = (pw_ff.val == v_ff);
   assign walk_end = up_ff ? (p_ff == highest_ff) : (p_ff == lowest_ff);
   assign walk_more = up_ff ? (bk_rd.val <= v_ff) : (bk_rd.val >= v_ff);
   assign ins_edge = walk_end;
   assign take_idx = (stk_cnt_ff != '0) ? stk_rdata : fresh_ff;

   always_comb begin
      moving  = 1'b0;
      new_val = bk_rd.val;
      case (cmd_ff)
         cbmt_pkg::CMD_INC: begin
            moving  = (bk_rd.val != cbmt_pkg::CNT_MAX);
            new_val = bk_rd.val + 1'b1;
         end
         cbmt_pkg::CMD_DEC: begin
            moving  = (bk_rd.val != cbmt_pkg::CNT_MIN);
            new_val = bk_rd.val - 1'b1;
         end
         cbmt_pkg::CMD_CLR: begin
            moving  = (bk_rd.val != '0);
            new_val = '0;
         end
         default: begin
            moving  = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbmt_pkg::ST_IDLE: if (req_acc) state_in = cbmt_pkg::ST_BOC;
         cbmt_pkg::ST_BOC:  state_in = cbmt_pkg::ST_BRD;
         cbmt_pkg::ST_BRD:  state_in = moving ? cbmt_pkg::ST_WALK : cbmt_pkg::ST_HRD;
         cbmt_pkg::ST_WALK: begin
            if (walk_eq) state_in = cbmt_pkg::ST_TRD;
            else if (walk_end) state_in = cbmt_pkg::ST_INS;
            else state_in = cbmt_pkg::ST_WCHK;
         end
         cbmt_pkg::ST_WCHK: state_in = walk_more ? cbmt_pkg::ST_WALK : cbmt_pkg::ST_INS;
         cbmt_pkg::ST_INS:  state_in = ins_edge ? cbmt_pkg::ST_INSP : cbmt_pkg::ST_INSQ;
         cbmt_pkg::ST_INSQ: state_in = cbmt_pkg::ST_INSP;
         cbmt_pkg::ST_INSP: state_in = cbmt_pkg::ST_TRD;
         cbmt_pkg::ST_TRD:  state_in = cbmt_pkg::ST_TWR;
         cbmt_pkg::ST_TWR:  state_in = cbmt_pkg::ST_BCHK;
         cbmt_pkg::ST_BCHK: begin
            state_in = (bk_rd.size == cbmt_pkg::SIZE_W'(1)) ? cbmt_pkg::ST_RLP
                                                            : cbmt_pkg::ST_BOCW;
         end
         cbmt_pkg::ST_RLP:  state_in = (b_ff == lowest_ff) ? cbmt_pkg::ST_RLN
                                                           : cbmt_pkg::ST_RLPW;
         cbmt_pkg::ST_RLPW: state_in = cbmt_pkg::ST_RLN;
         cbmt_pkg::ST_RLN:  state_in = (b_ff == highest_ff) ? cbmt_pkg::ST_BOCW
                                                            : cbmt_pkg::ST_RLNW;
         cbmt_pkg::ST_RLNW: state_in = cbmt_pkg::ST_BOCW;
         cbmt_pkg::ST_BOCW: state_in = cbmt_pkg::ST_HRD;
         cbmt_pkg::ST_HRD:  state_in = cbmt_pkg::ST_HCAP;
         cbmt_pkg::ST_HCAP: if (rsp_load) state_in = cbmt_pkg::ST_IDLE;
         default:           state_in = cbmt_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      idx_in = idx_ff;   cmd_in = cmd_ff;   b_in = b_ff;   p_in = p_ff;
      q_in = q_ff;       t_in = t_ff;       pw_in = pw_ff; qw_in = qw_ff;
      v_in = v_ff;       cv_in = cv_ff;     up_in = up_ff;
      lowest_in = lowest_ff;  highest_in = highest_ff;
      stk_cnt_in = stk_cnt_ff; fresh_in = fresh_ff;
      boc_vld_in = boc_vld_ff;
      rsp_cv_in = rsp_cv_ff; rsp_max_in = rsp_max_ff; rsp_num_in = rsp_num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready = (state_ff == cbmt_pkg::ST_IDLE);
      boc_we = 1'b0;  boc_waddr = idx_ff;  boc_wdata = t_ff;
      boc_raddr = req_ch.counter_index;
      bk_we = 1'b0;   bk_waddr = t_ff;     bk_wdata = bk_rd;  bk_raddr = highest_ff;
      stk_we = 1'b0;
      case (state_ff)
         cbmt_pkg::ST_IDLE: begin
            if (req_acc) begin
               idx_in = req_ch.counter_index;
               cmd_in = cbmt_pkg::cmd_type'(req_ch.command);
            end
         end
         cbmt_pkg::ST_BOC: begin
            b_in     = boc_vld_ff[idx_ff] ? boc_rdata : '0;
            bk_raddr = b_in;
         end
         cbmt_pkg::ST_BRD: begin
            p_in  = b_ff;
            pw_in = bk_rd;
            v_in  = new_val;
            up_in = (new_val > bk_rd.val);
            cv_in = bk_rd.val;
         end
         cbmt_pkg::ST_WALK: begin
            t_in     = p_ff;
            bk_raddr = up_ff ? pw_ff.next : pw_ff.prev;
         end
         cbmt_pkg::ST_WCHK: begin
            if (walk_more) begin
               p_in  = up_ff ? pw_ff.next : pw_ff.prev;
               pw_in = bk_rd;
            end else begin
               q_in  = up_ff ? pw_ff.next : pw_ff.prev;
               qw_in = bk_rd;
            end
         end
         cbmt_pkg::ST_INS: begin
            t_in = take_idx;
            if (stk_cnt_ff != '0) stk_cnt_in = stk_cnt_ff - 1'b1;
            else fresh_in = fresh_ff + 1'b1;
            bk_we    = 1'b1;
            bk_waddr = take_idx;
            bk_wdata = '{val: v_ff, size: '0,
                         prev: up_ff ? p_ff : q_ff, next: up_ff ? q_ff : p_ff};
            if (ins_edge) begin
               if (up_ff) highest_in = take_idx;
               else lowest_in = take_idx;
            end
         end
         cbmt_pkg::ST_INSQ: begin
            bk_we    = 1'b1;
            bk_waddr = q_ff;
            bk_wdata = qw_ff;
            if (up_ff) bk_wdata.prev = t_ff;
            else bk_wdata.next = t_ff;
         end
         cbmt_pkg::ST_INSP: begin
            bk_we    = 1'b1;
            bk_waddr = p_ff;
            bk_wdata = pw_ff;
            if (up_ff) bk_wdata.next = t_ff;
            else bk_wdata.prev = t_ff;
         end
         cbmt_pkg::ST_TRD: begin
            bk_raddr = t_ff;
         end
         cbmt_pkg::ST_TWR: begin
            bk_we         = 1'b1;
            bk_waddr      = t_ff;
            bk_wdata      = bk_rd;
            bk_wdata.size = bk_rd.size + 1'b1;
            bk_raddr      = b_ff;
         end
         cbmt_pkg::ST_BCHK: begin
            if (bk_rd.size == cbmt_pkg::SIZE_W'(1)) begin
               // bucket empties: unlink it and return it to the free stack
               pw_in      = bk_rd;
               stk_we     = 1'b1;
               stk_cnt_in = stk_cnt_ff + 1'b1;
            end else begin
               bk_we         = 1'b1;
               bk_waddr      = b_ff;
               bk_wdata      = bk_rd;
               bk_wdata.size = bk_rd.size - 1'b1;
            end
         end
         cbmt_pkg::ST_RLP: begin
            if (b_ff == lowest_ff) lowest_in = pw_ff.next;
            bk_raddr = pw_ff.prev;
         end
         cbmt_pkg::ST_RLPW: begin
            bk_we         = 1'b1;
            bk_waddr      = pw_ff.prev;
            bk_wdata      = bk_rd;
            bk_wdata.next = pw_ff.next;
         end
         cbmt_pkg::ST_RLN: begin
            if (b_ff == highest_ff) highest_in = pw_ff.prev;
            bk_raddr = pw_ff.next;
         end
         cbmt_pkg::ST_RLNW: begin
            bk_we         = 1'b1;
            bk_waddr      = pw_ff.next;
            bk_wdata      = bk_rd;
            bk_wdata.prev = pw_ff.prev;
         end
         cbmt_pkg::ST_BOCW: begin
            boc_we             = 1'b1;
            boc_vld_in[idx_ff] = 1'b1;
            cv_in              = v_ff;
         end
         cbmt_pkg::ST_HRD: begin
            bk_raddr = highest_ff;
         end
         cbmt_pkg::ST_HCAP: begin
            bk_raddr = highest_ff;
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_cv_in    = cv_ff;
               rsp_max_in   = bk_rd.val;
               rsp_num_in   = bk_rd.size;
            end
         end
         default: begin
            bk_raddr = highest_ff;
         end
      endcase
   end

   assign b0_vld_in = b0_vld_ff || (bk_we && bk_waddr == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbmt_pkg::ST_IDLE;
         lowest_ff    <= '0;
         highest_ff   <= '0;
         stk_cnt_ff   <= '0;
         fresh_ff     <= cbmt_pkg::BIDX_W'(1);
         boc_vld_ff   <= '0;
         b0_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         stk_cnt_ff   <= stk_cnt_in;
         fresh_ff     <= fresh_in;
         boc_vld_ff   <= boc_vld_in;
         b0_vld_ff    <= b0_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  cmd_ff <= cmd_in;  b_ff <= b_in;  p_ff <= p_in;
      q_ff <= q_in;      t_ff <= t_in;      pw_ff <= pw_in; qw_ff <= qw_in;
      v_ff <= v_in;      cv_ff <= cv_in;    up_ff <= up_in;
      bk_raddr_q_ff <= bk_raddr;
      rsp_cv_ff <= rsp_cv_in; rsp_max_ff <= rsp_max_in; rsp_num_ff <= rsp_num_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.counter_value = rsp_cv_ff;
   assign rsp_ch.max_value     = rsp_max_ff;
   assign rsp_ch.num_at_max    = rsp_num_ff;

   `CBMT_ASSERT(a_pool_nonempty, (state_ff == cbmt_pkg::ST_INS) |-> (stk_cnt_ff != '0 || fresh_ff < cbmt_pkg::BIDX_W'(cbmt_pkg::NUM_BUCKETS)))
   `CBMT_NEVER(a_same_bucket, (state_ff == cbmt_pkg::ST_TWR) && (t_ff == b_ff))
   `CBMT_ASSERT(a_stack_bound, stk_cnt_ff < cbmt_pkg::BIDX_W'(cbmt_pkg::NUM_BUCKETS))
endmodule

// ===== rtl/core/cbmt_ram.sv =====
`timescale 1ns / 1ps
module cbmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
